@@ rtl/core/mbsd_pkg.sv @@
package mbsd_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LEN_W = 21;
	localparam int LEN_KEEP_W = LEN_W - 7;

	typedef enum logic [4:0] {
		KIND_NOTE_OFF    = 5'd0,
		KIND_NOTE_ON     = 5'd1,
		KIND_POLY_PRESS  = 5'd2,
		KIND_CTRL_CHANGE = 5'd3,
		KIND_PROG_CHANGE = 5'd4,
		KIND_CHAN_PRESS  = 5'd5,
		KIND_PITCH_BEND  = 5'd6,
		KIND_SYSEX_BYTE  = 5'd7,
		KIND_QFRAME      = 5'd8,
		KIND_SONG_POS    = 5'd9,
		KIND_SONG_SEL    = 5'd10,
		KIND_TUNE        = 5'd11,
		KIND_START       = 5'd12,
		KIND_CONTINUE    = 5'd13,
		KIND_STOP        = 5'd14,
		KIND_RESET       = 5'd15,
		KIND_SYSEX_EMPTY = 5'd16
	} kind_t;

	localparam logic [7:0] ST_SYSEX    = 8'hF0;
	localparam logic [7:0] ST_QFRAME   = 8'hF1;
	localparam logic [7:0] ST_SONG_POS = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL = 8'hF3;
	localparam logic [7:0] ST_TUNE     = 8'hF6;
	localparam logic [7:0] ST_START    = 8'hFA;
	localparam logic [7:0] ST_CONTINUE = 8'hFB;
	localparam logic [7:0] ST_STOP     = 8'hFC;
	localparam logic [7:0] ST_RESET    = 8'hFF;
	localparam logic [3:0] SYS_NIBBLE  = 4'hF;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  channel;
		logic [7:0]  byte_a;
		logic [7:0]  byte_b;
		logic        last;
	} qent_t;

	typedef struct packed {
		logic push;
	} qctl_t;

	function automatic logic takes_data(logic [7:0] st);
		return (st[7] && st[7:4] != SYS_NIBBLE) || (st[7:2] == ST_SYSEX[7:2]);
	endfunction

	function automatic logic [6:0] sat7(logic [7:0] v);
		return v[7] ? 7'h7F : v[6:0];
	endfunction

endpackage

@@ rtl/core/mbsd_ifs.sv @@
interface mbsd_byte_if;
	import mbsd_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface mbsd_msg_if;
	import mbsd_pkg::*;

	logic        valid;
	logic        ready;
	logic [4:0]  msg_kind;
	logic [3:0]  channel;
	logic [6:0]  data_first;
	logic [6:0]  data_second;
	logic [13:0] value_wide;
	logic [7:0]  sysex_data;
	logic        sysex_last;

	modport source (
		output valid, output msg_kind, output channel, output data_first,
		output data_second, output value_wide, output sysex_data, output sysex_last,
		input ready
	);
	modport sink (
		input valid, input msg_kind, input channel, input data_first,
		input data_second, input value_wide, input sysex_data, input sysex_last,
		output ready
	);
endinterface

@@ rtl/core/midi_byte_stream_decoder.sv @@
// Channel  Direction  Handshake      Carries
// rx       in         valid/ready    rx_byte, one received byte per transfer
// msg      out        valid/ready    one decoded message per transfer
//
// One byte is taken per cycle while the four-entry message queue has room.
// A message that a byte completes is written into the queue and then moved
// into the output register that drives msg; a stalled msg keeps it queued.
// A stalled msg fills the queue; rx then stalls until an entry drains.
// Reset at once clears the parser state and queue and drops msg.valid.
module midi_byte_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	mbsd_byte_if.sink  rx,
	mbsd_msg_if.source msg
);
	import mbsd_pkg::*;

	qctl_t qctl;
	qent_t wr_ent;
	qent_t rd_ent;
	logic  qfull;
	logic  qempty;
	logic  qpop;

	mbsd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.qctl_o (qctl),
		.qfull  (qfull),
		.qent   (wr_ent)
	);

	mbsd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qctl_i (qctl),
		.wr_ent (wr_ent),
		.pop    (qpop),
		.full   (qfull),
		.empty  (qempty),
		.rd_ent (rd_ent)
	);

	mbsd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (rd_ent),
		.empty  (qempty),
		.pop    (qpop),
		.msg    (msg)
	);

endmodule

@@ rtl/core/mbsd_front.sv @@
module mbsd_front (
	input  logic              clk,
	input  logic              arst_n,
	mbsd_byte_if.sink         rx,
	output mbsd_pkg::qctl_t   qctl_o,
	input  logic              qfull,
	output mbsd_pkg::qent_t   qent
);
	import mbsd_pkg::*;

	logic [7:0]       rs_q, rs_n;
	logic [1:0]       bc_q, bc_n;
	logic [7:0]       held_q, held_n;
	logic [LEN_W-1:0] la_q, la_n;
	logic [LEN_W-1:0] pl_q, pl_n;
	logic             inp_q, inp_n;

	logic             accept;
	logic             push;
	logic             go;
	logic [1:0]       bc_eff;
	logic [7:0]       x;
	logic [LEN_W-1:0] la_new;
	qent_t            ent;

	assign x = rx.rx_byte;
	assign rx.ready = !qfull;
	assign accept = rx.valid && rx.ready;

	always_comb begin
		rs_n = rs_q;
		bc_n = bc_q;
		held_n = held_q;
		la_n = la_q;
		pl_n = pl_q;
		inp_n = inp_q;
		push = 1'b0;
		ent = '0;
		go = 1'b0;
		bc_eff = bc_q;
		la_new = la_q;
		if (inp_q) begin
			push = 1'b1;
			ent.kind = KIND_SYSEX_BYTE;
			ent.byte_a = x;
			ent.last = (pl_q <= LEN_W'(1));
			if (pl_q <= LEN_W'(1)) begin
				pl_n = '0;
				inp_n = 1'b0;
			end else begin
				pl_n = pl_q - LEN_W'(1);
			end
		end else begin
			go = 1'b1;
			if (bc_q == 2'd0) begin
				if (x[7]) begin
					go = 1'b0;
					rs_n = x;
					if (takes_data(x)) begin
						bc_n = 2'd1;
					end else begin
						case (x)
							ST_TUNE: begin
								push = 1'b1;
								ent.kind = KIND_TUNE;
							end
							ST_START: begin
								push = 1'b1;
								ent.kind = KIND_START;
							end
							ST_CONTINUE: begin
								push = 1'b1;
								ent.kind = KIND_CONTINUE;
							end
							ST_STOP: begin
								push = 1'b1;
								ent.kind = KIND_STOP;
							end
							ST_RESET: begin
								push = 1'b1;
								ent.kind = KIND_RESET;
							end
							default: begin
								push = 1'b0;
							end
						endcase
					end
				end else if (!takes_data(rs_q)) begin
					go = 1'b0;
				end else begin
					bc_eff = 2'd1;
				end
			end
			if (go) begin
				if (!takes_data(rs_q)) begin
					bc_n = 2'd0;
				end else if (rs_q[7:4] != SYS_NIBBLE) begin
					ent.kind = kind_t'({2'b00, rs_q[6:4]});
					ent.channel = rs_q[3:0];
					if (ent.kind == KIND_PROG_CHANGE || ent.kind == KIND_CHAN_PRESS) begin
						push = 1'b1;
						ent.byte_a = x;
						bc_n = 2'd0;
					end else if (bc_eff == 2'd1) begin
						held_n = x;
						bc_n = 2'd2;
					end else begin
						push = 1'b1;
						ent.byte_a = held_q;
						ent.byte_b = x;
						bc_n = 2'd0;
					end
				end else begin
					case (rs_q)
						ST_SYSEX: begin
							if (bc_eff == 2'd1) begin
								la_new = {{LEN_KEEP_W{1'b0}}, x[6:0]};
							end else begin
								la_new = {la_q[LEN_KEEP_W-1:0], x[6:0]};
							end
							la_n = la_new;
							if (x[7] && bc_eff != 2'd3) begin
								bc_n = bc_eff + 2'd1;
							end else begin
								bc_n = 2'd0;
								if (la_new == '0) begin
									push = 1'b1;
									ent.kind = KIND_SYSEX_EMPTY;
								end else begin
									pl_n = la_new;
									inp_n = 1'b1;
								end
							end
						end
						ST_QFRAME: begin
							push = 1'b1;
							ent.kind = KIND_QFRAME;
							ent.byte_a = x;
							bc_n = 2'd0;
						end
						ST_SONG_POS: begin
							if (bc_eff == 2'd1) begin
								held_n = x;
								bc_n = 2'd2;
							end else begin
								push = 1'b1;
								ent.kind = KIND_SONG_POS;
								ent.byte_a = held_q;
								ent.byte_b = x;
								bc_n = 2'd0;
							end
						end
						default: begin
							push = 1'b1;
							ent.kind = KIND_SONG_SEL;
							ent.byte_a = x;
							bc_n = 2'd0;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q <= '0;
			bc_q <= '0;
			held_q <= '0;
			la_q <= '0;
			pl_q <= '0;
			inp_q <= 1'b0;
		end else if (accept) begin
			rs_q <= rs_n;
			bc_q <= bc_n;
			held_q <= held_n;
			la_q <= la_n;
			pl_q <= pl_n;
			inp_q <= inp_n;
		end
	end

	assign qctl_o.push = accept && push;
	assign qent = ent;

endmodule

@@ rtl/core/mbsd_queue.sv @@
module mbsd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  mbsd_pkg::qctl_t qctl_i,
	input  mbsd_pkg::qent_t wr_ent,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output mbsd_pkg::qent_t rd_ent
);
	import mbsd_pkg::*;

	qent_t             slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign rd_ent = slots_q[rptr_q];

	always_ff @(posedge clk) begin
		if (qctl_i.push) begin
			slots_q[wptr_q] <= wr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (qctl_i.push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({qctl_i.push, do_pop})
				2'b10: cnt_q <= cnt_q + QCNT_W'(1);
				2'b01: cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/core/mbsd_back.sv @@
module mbsd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mbsd_pkg::qent_t head,
	input  logic            empty,
	output logic            pop,
	mbsd_msg_if.source      msg
);
	import mbsd_pkg::*;

	logic        vld_q;
	logic [4:0]  kind_q;
	logic [3:0]  ch_q;
	logic [6:0]  df_q;
	logic [6:0]  ds_q;
	logic [13:0] vw_q;
	logic [7:0]  sd_q;
	logic        sl_q;

	logic [3:0]  ch_c;
	logic [6:0]  df_c;
	logic [6:0]  ds_c;
	logic [13:0] vw_c;
	logic [7:0]  sd_c;
	logic        sl_c;

	assign pop = !empty && (!vld_q || msg.ready);

	always_comb begin
		ch_c = '0;
		df_c = '0;
		ds_c = '0;
		vw_c = '0;
		sd_c = '0;
		sl_c = 1'b0;
		case (head.kind)
			KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_PRESS, KIND_CTRL_CHANGE: begin
				ch_c = head.channel;
				df_c = sat7(head.byte_a);
				ds_c = sat7(head.byte_b);
			end
			KIND_PROG_CHANGE, KIND_CHAN_PRESS: begin
				ch_c = head.channel;
				df_c = sat7(head.byte_a);
			end
			KIND_PITCH_BEND: begin
				ch_c = head.channel;
				df_c = sat7(head.byte_a);
				ds_c = sat7(head.byte_b);
				vw_c = {sat7(head.byte_b), sat7(head.byte_a)};
			end
			KIND_SYSEX_BYTE: begin
				sd_c = head.byte_a;
				sl_c = head.last;
			end
			KIND_QFRAME: begin
				df_c = {4'b0000, head.byte_a[6:4]};
				ds_c = {3'b000, head.byte_a[3:0]};
			end
			KIND_SONG_POS: begin
				df_c = sat7(head.byte_a);
				ds_c = sat7(head.byte_b);
				vw_c = {sat7(head.byte_b), sat7(head.byte_a)};
			end
			KIND_SONG_SEL: begin
				df_c = sat7(head.byte_a);
			end
			default: begin
				ch_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (msg.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head.kind;
			ch_q <= ch_c;
			df_q <= df_c;
			ds_q <= ds_c;
			vw_q <= vw_c;
			sd_q <= sd_c;
			sl_q <= sl_c;
		end
	end

	assign msg.valid = vld_q;
	assign msg.msg_kind = kind_q;
	assign msg.channel = ch_q;
	assign msg.data_first = df_q;
	assign msg.data_second = ds_q;
	assign msg.value_wide = vw_q;
	assign msg.sysex_data = sd_q;
	assign msg.sysex_last = sl_q;

endmodule

@@ rtl/core/mbsd_checker.sv @@
module mbsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_ready,
	input logic [4:0]  msg_kind,
	input logic [3:0]  channel,
	input logic [6:0]  data_first,
	input logic [6:0]  data_second,
	input logic [13:0] value_wide,
	input logic [7:0]  sysex_data,
	input logic        sysex_last
);
	import mbsd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_ready |=> msg_valid && $stable(msg_kind) && $stable(sysex_data))
		else $error("msg transfer changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid |-> msg_kind <= KIND_SYSEX_EMPTY)
		else $error("msg_kind out of range");

	a_wide: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && (msg_kind == KIND_PITCH_BEND || msg_kind == KIND_SONG_POS)
		|-> value_wide == {data_second, data_first})
		else $error("value_wide does not match the two data bytes");

	a_sysex_fields: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_kind != KIND_SYSEX_BYTE |-> sysex_data == 8'd0 && !sysex_last)
		else $error("sysex fields set on a non-sysex message");

	a_chan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_kind > KIND_PITCH_BEND |-> channel == 4'd0)
		else $error("channel set on a system message");

endmodule

bind midi_byte_stream_decoder mbsd_checker u_mbsd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.msg_valid   (msg.valid),
	.msg_ready   (msg.ready),
	.msg_kind    (msg.msg_kind),
	.channel     (msg.channel),
	.data_first  (msg.data_first),
	.data_second (msg.data_second),
	.value_wide  (msg.value_wide),
	.sysex_data  (msg.sysex_data),
	.sysex_last  (msg.sysex_last)
);
